// ===== design/rgag_pkg.sv =====
// Shared widths, register indexes and pipeline tag type of the radial glow alpha generator.
`timescale 1ns / 1ps

package rgag_pkg;

    // Field widths
    localparam int COORD_W = 9;
    localparam int RAD_W   = 8;
    localparam int CH_W    = 8;
    localparam int DIM_W   = 7;
    localparam int S_W     = 2 * RAD_W;

    // Largest radius the sprite geometry honours, and the default fraction width
    localparam int MAX_RADIUS    = 255;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [RAD_W-1:0] RAD_LIMIT =
        (MAX_RADIUS > 255) ? 8'd255 : RAD_W'(MAX_RADIUS);

    // Falloff used when the register holds a negative value
    localparam logic [DIM_W-1:0] DIM_NEG   = 7'd4;
    localparam logic [CH_W-1:0]  ALPHA_MAX = 8'hFF;

    // Configuration register map
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FALLOFF = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED     = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE    = 3'd4;

    // Reset values of the registers
    localparam logic [RAD_W-1:0]        RADIUS_RST  = 8'd16;
    localparam logic signed [CH_W-1:0]  FALLOFF_RST = 8'sd4;
    localparam logic [CH_W-1:0]         COLOUR_RST  = 8'hFF;

    // Control bits that travel alongside each request through the pipeline
    typedef struct packed {
        logic valid;
        logic in_circle;
    } t_tag;

endpackage

// ===== design/radial_glow_alpha_generator.sv =====
// Top level of the radial glow alpha generator: register port, pipeline and output buffering.
`timescale 1ns / 1ps

// The block takes one pixel coordinate per clock and returns one RGBA pixel per clock, in
// order, while the output keeps accepting them. The pipeline depth comes mostly from the
// square root and the two dividers, which each produce one result bit per pipeline stage.
// Alpha follows an inverse-square falloff from the sprite centre and is zero outside the
// circle; the colour comes straight from the registers. A skid entry behind the output
// register takes one more result when the output is refused, so the pipeline keeps moving
// until a second result waits; the input then stays blocked until the skid entry has moved
// up into the output register.
// Registers may only be changed while no request is in flight.
module radial_glow_alpha_generator #(
    parameter int FRAC_BITS = rgag_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgag_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Coordinate stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // pixel_x[8:0], pixel_y[17:9], zeros
    // Pixel stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata   // red, green, blue, alpha
);
    import rgag_pkg::*;

    localparam int ROOT_W = RAD_W + FRAC_BITS;
    localparam int PROD_W = ROOT_W + DIM_W;
    localparam int REL_W  = DIM_W + FRAC_BITS;
    localparam int RSQ_W  = 2 * REL_W;
    localparam int NUM2_W = CH_W + 2 * FRAC_BITS - 2;

    localparam logic [REL_W-1:0]  HALF = REL_W'({1'b1, {(FRAC_BITS - 1){1'b0}}});
    localparam logic [NUM2_W-1:0] NUM2 = {ALPHA_MAX, {(2 * FRAC_BITS - 2){1'b0}}};

    // Configuration registers
    logic [RAD_W-1:0]       r_glow_radius;
    logic signed [CH_W-1:0] r_falloff_scale;
    logic [CH_W-1:0]        r_color_red;
    logic [CH_W-1:0]        r_color_green;
    logic [CH_W-1:0]        r_color_blue;

    logic                   w_wr;
    logic [IDX_W-1:0]       w_idx;
    logic [RAD_W-1:0]       w_rad;
    logic [DIM_W-1:0]       w_dim;
    logic                   w_en;

    t_tag                   w_front_tag;
    logic [S_W-1:0]         w_sum_sq;
    t_tag                   w_root_tag;
    logic [ROOT_W-1:0]      w_dist;
    t_tag                   w_d1_tag;
    logic [REL_W-1:0]       w_quot1;
    t_tag                   w_d2_tag;
    logic [CH_W-1:0]        w_quot2;
    logic [CH_W-1:0]        w_alpha;

    t_tag                   r_m_tag;
    logic [PROD_W-1:0]      r_m_prod;
    t_tag                   r_rel_tag;
    logic [REL_W-1:0]       r_rel;
    t_tag                   r_sq_tag;
    logic [RSQ_W-1:0]       r_rsq;

    logic                   r_out_valid;
    logic [CH_W-1:0]        r_out_alpha;
    logic                   r_skid_valid;
    logic [CH_W-1:0]        r_skid_alpha;
    logic                   n_out_valid;
    logic [CH_W-1:0]        n_out_alpha;
    logic                   n_skid_valid;
    logic [CH_W-1:0]        n_skid_alpha;
    logic                   w_take;

    // Register writes complete in the access cycle
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glow_radius   <= RADIUS_RST;
            r_falloff_scale <= FALLOFF_RST;
            r_color_red     <= COLOUR_RST;
            r_color_green   <= COLOUR_RST;
            r_color_blue    <= COLOUR_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RADIUS:  r_glow_radius   <= pwdata[RAD_W-1:0];
                REG_FALLOFF: r_falloff_scale <= pwdata[CH_W-1:0];
                REG_RED:     r_color_red     <= pwdata[CH_W-1:0];
                REG_GREEN:   r_color_green   <= pwdata[CH_W-1:0];
                REG_BLUE:    r_color_blue    <= pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (w_idx)
            REG_RADIUS:  prdata = 32'(r_glow_radius);
            REG_FALLOFF: prdata = 32'(unsigned'(r_falloff_scale));
            REG_RED:     prdata = 32'(r_color_red);
            REG_GREEN:   prdata = 32'(r_color_green);
            REG_BLUE:    prdata = 32'(r_color_blue);
            default:     prdata = '0;
        endcase
    end

    // Effective radius and falloff
    assign w_rad = (r_glow_radius > RAD_LIMIT) ? RAD_LIMIT : r_glow_radius;
    assign w_dim = r_falloff_scale[CH_W-1] ? DIM_NEG : r_falloff_scale[DIM_W-1:0];

    // The whole pipeline moves together while the skid entry is free
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    rgag_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (s_axis_tvalid),
        .i_pixel_x (s_axis_tdata[COORD_W-1:0]),
        .i_pixel_y (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_rad     (w_rad),
        .o_tag     (w_front_tag),
        .o_sum_sq  (w_sum_sq)
    );

    // Distance in fixed point: root of the squared distance scaled by 2^(2F)
    rgag_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_tag      (w_front_tag),
        .i_radicand ({w_sum_sq, {(2 * FRAC_BITS){1'b0}}}),
        .o_tag      (w_root_tag),
        .o_root     (w_dist)
    );

    // Scale the distance by the falloff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag <= '0;
        end else if (w_en) begin
            r_m_tag <= w_root_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_prod <= PROD_W'(w_dist) * PROD_W'(w_dim);
        end
    end

    // Relative distance: scaled distance over the radius
    rgag_div #(
        .NUM_W (PROD_W),
        .DEN_W (RAD_W),
        .Q_W   (REL_W)
    ) u_div_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r_m_tag),
        .i_num   (r_m_prod),
        .i_den   (w_rad),
        .o_tag   (w_d1_tag),
        .o_quot  (w_quot1)
    );

    // Add one half, then square; a zero radius leaves only the half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_tag <= '0;
            r_sq_tag  <= '0;
        end else if (w_en) begin
            r_rel_tag <= w_d1_tag;
            r_sq_tag  <= r_rel_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rel <= (w_rad == '0) ? HALF : w_quot1 + HALF;
            r_rsq <= RSQ_W'(r_rel) * RSQ_W'(r_rel);
        end
    end

    // Inverse-square alpha; the half offset keeps the quotient within eight bits
    rgag_div #(
        .NUM_W (NUM2_W),
        .DEN_W (RSQ_W),
        .Q_W   (CH_W)
    ) u_div_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r_sq_tag),
        .i_num   (NUM2),
        .i_den   (r_rsq),
        .o_tag   (w_d2_tag),
        .o_quot  (w_quot2)
    );

    assign w_alpha = w_d2_tag.in_circle ? w_quot2 : '0;

    // Output register with one skid entry behind it
    assign w_take = r_out_valid & m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_alpha  = r_out_alpha;
        n_skid_valid = r_skid_valid;
        n_skid_alpha = r_skid_alpha;
        if (w_take) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_valid  = 1'b1;
                n_out_alpha  = r_skid_alpha;
                n_skid_valid = 1'b0;
            end
        end else if (w_d2_tag.valid) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_alpha = w_alpha;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_alpha = w_alpha;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_alpha  <= n_out_alpha;
        r_skid_alpha <= n_skid_alpha;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_alpha, r_color_blue, r_color_green, r_color_red};

    // The skid entry is only ever occupied behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only when the output result was refused
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid entry filled although the output was free");

    // A taken result is replaced by the skid entry at once
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move into the output register");

    // For a pixel inside the circle the relative distance cannot wrap below one half
    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rel_tag.valid && r_rel_tag.in_circle) |-> (r_rel >= HALF))
        else $error("relative distance wrapped for a pixel inside the circle");

endmodule

// ===== design/rgag_front.sv =====
// Front end: distance offsets, squares and the inside-circle test over three stages.
`timescale 1ns / 1ps

module rgag_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rgag_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [rgag_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [rgag_pkg::RAD_W-1:0]   i_rad,
    output rgag_pkg::t_tag               o_tag,
    output logic [rgag_pkg::S_W-1:0]     o_sum_sq
);
    import rgag_pkg::*;

    localparam int SQ_W  = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 1;

    logic [COORD_W-1:0] w_rad_ext;
    logic [COORD_W-1:0] w_ax;
    logic [COORD_W-1:0] w_ay;
    logic [SUM_W-1:0]   w_sum;
    logic               w_inside;

    logic               r_v1;
    logic [COORD_W-1:0] r_ax;
    logic [COORD_W-1:0] r_ay;
    logic               r_v2;
    logic [SQ_W-1:0]    r_ax_sq;
    logic [SQ_W-1:0]    r_ay_sq;
    logic [S_W-1:0]     r_rad_sq;
    t_tag               r_tag3;
    logic [S_W-1:0]     r_sum_sq;

    // Stage 1: absolute offsets from the centre
    assign w_rad_ext = COORD_W'(i_rad);
    assign w_ax = (i_pixel_x >= w_rad_ext) ? i_pixel_x - w_rad_ext : w_rad_ext - i_pixel_x;
    assign w_ay = (i_pixel_y >= w_rad_ext) ? i_pixel_y - w_rad_ext : w_rad_ext - i_pixel_y;

    // Stage 3: sum of squares and the test against the squared radius
    assign w_sum    = SUM_W'(r_ax_sq) + SUM_W'(r_ay_sq);
    assign w_inside = w_sum <= SUM_W'(r_rad_sq);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_tag3 <= '0;
        end else if (i_en) begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_tag3 <= '{valid: r_v2, in_circle: w_inside};
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax     <= w_ax;
            r_ay     <= w_ay;
            r_ax_sq  <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_ay_sq  <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_rad_sq <= S_W'(i_rad) * S_W'(i_rad);
            // Only the low bits matter once the point is known to be inside
            r_sum_sq <= w_sum[S_W-1:0];
        end
    end

    assign o_tag    = r_tag3;
    assign o_sum_sq = r_sum_sq;

endmodule

// ===== design/rgag_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rgag_sqrt #(
    parameter int ROOT_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rgag_pkg::t_tag        i_tag,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    output rgag_pkg::t_tag        o_tag,
    output logic [ROOT_W-1:0]     o_root
);
    import rgag_pkg::*;

    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic [REM_W-1:0]  r_rem  [0:ROOT_W-2];
    logic [RAD2_W-1:0] r_rad  [0:ROOT_W-2];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_tag              r_tag  [0:ROOT_W-1];

    genvar i;
    for (i = 0; i < ROOT_W; i++) begin : g_step
        logic [REM_W-1:0]  w_rem_in;
        logic [RAD2_W-1:0] w_rad_in;
        logic [ROOT_W-1:0] w_root_in;
        t_tag              w_tag_in;
        logic [REM_W-1:0]  w_rem_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (i == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_rad_in  = i_radicand;
            assign w_root_in = '0;
            assign w_tag_in  = i_tag;
        end else begin : g_next
            assign w_rem_in  = r_rem[i-1];
            assign w_rad_in  = r_rad[i-1];
            assign w_root_in = r_root[i-1];
            assign w_tag_in  = r_tag[i-1];
        end

        // Bring down the next two radicand bits and try the root bit
        assign w_rem_sh = {w_rem_in[REM_W-3:0], w_rad_in[RAD2_W-1 -: 2]};
        assign w_trial  = REM_W'({w_root_in, 2'b01});
        assign w_ge     = w_rem_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[i] <= '0;
            end else if (i_en) begin
                r_tag[i] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[i] <= {w_root_in[ROOT_W-2:0], w_ge};
            end
        end

        // The last stage needs no remainder or radicand
        if (i < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= w_ge ? w_rem_sh - w_trial : w_rem_sh;
                    r_rad[i] <= w_rad_in << 2;
                end
            end
        end
    end

    assign o_tag  = r_tag[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== design/rgag_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for quotients known to fit Q_W bits.
`timescale 1ns / 1ps

module rgag_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8,
    parameter int Q_W   = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rgag_pkg::t_tag     i_tag,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output rgag_pkg::t_tag     o_tag,
    output logic [Q_W-1:0]     o_quot
);
    import rgag_pkg::*;

    logic [DEN_W-1:0] r_rem  [0:Q_W-2];
    logic [Q_W-1:0]   r_low  [0:Q_W-2];
    logic [DEN_W-1:0] r_den  [0:Q_W-2];
    logic [Q_W-1:0]   r_quot [0:Q_W-1];
    t_tag             r_tag  [0:Q_W-1];

    genvar i;
    for (i = 0; i < Q_W; i++) begin : g_step
        logic [DEN_W-1:0] w_rem_in;
        logic [Q_W-1:0]   w_low_in;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_quot_in;
        t_tag             w_tag_in;
        logic [DEN_W:0]   w_rem_sh;
        logic             w_ge;

        if (i == 0) begin : g_first
            // The upper numerator bits are below the divisor for every in-circle request with a nonzero divisor
            assign w_rem_in  = DEN_W'(i_num[NUM_W-1:Q_W]);
            assign w_low_in  = i_num[Q_W-1:0];
            assign w_den_in  = i_den;
            assign w_quot_in = '0;
            assign w_tag_in  = i_tag;
        end else begin : g_next
            assign w_rem_in  = r_rem[i-1];
            assign w_low_in  = r_low[i-1];
            assign w_den_in  = r_den[i-1];
            assign w_quot_in = r_quot[i-1];
            assign w_tag_in  = r_tag[i-1];
        end

        assign w_rem_sh = {w_rem_in, w_low_in[Q_W-1]};
        assign w_ge     = w_rem_sh >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[i] <= '0;
            end else if (i_en) begin
                r_tag[i] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[i] <= {w_quot_in[Q_W-2:0], w_ge};
            end
        end

        // The last stage keeps only the quotient
        if (i < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= DEN_W'(w_ge ? w_rem_sh - {1'b0, w_den_in} : w_rem_sh);
                    r_low[i] <= w_low_in << 1;
                    r_den[i] <= w_den_in;
                end
            end
        end
    end

    assign o_tag  = r_tag[Q_W-1];
    assign o_quot = r_quot[Q_W-1];

endmodule

// ===== tb/radial_glow_alpha_generator_tb.sv =====
// Self-checking testbench for the radial glow alpha generator: streamed pixels against a predictor.
`timescale 1ns / 1ps

module radial_glow_alpha_generator_tb;
    import rgag_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int LATENCY  = 2 * FRAC + 30;
    localparam int HOLD_OFF = 300;

    // Output pixel as packed on m_axis_tdata, red in the lowest byte.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    // Holds a copy of the registers, predicts each pixel and checks the stream in order.
    class glow_scoreboard;
        logic [RAD_W-1:0] radius;
        logic [CH_W-1:0]  falloff;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        t_pixel           awaited[$];
        int               mismatches;

        function new();
            radius     = RADIUS_RST;
            falloff    = FALLOFF_RST;
            red        = COLOUR_RST;
            green      = COLOUR_RST;
            blue       = COLOUR_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CH_W-1:0] val);
            case (idx)
                REG_RADIUS:  radius  = val;
                REG_FALLOFF: falloff = val;
                REG_RED:     red     = val;
                REG_GREEN:   green   = val;
                REG_BLUE:    blue    = val;
                default: ;
            endcase
        endfunction

        // Integer square root, settling one result bit per step from the top.
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned acc;
            longint unsigned trial;
            acc = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = acc | (64'd1 << b);
                if (trial * trial <= v)
                    acc = trial;
            end
            return acc;
        endfunction

        // Inverse-square alpha in fixed point; zero outside the circle.
        function logic [CH_W-1:0] glow_alpha(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            longint unsigned rad;
            longint unsigned dim;
            longint unsigned ax;
            longint unsigned ay;
            longint unsigned dsq;
            longint unsigned dist_q;
            longint unsigned rel;
            longint unsigned quot;
            rad = (radius > RAD_LIMIT) ? RAD_LIMIT : radius;
            dim = falloff[CH_W-1] ? DIM_NEG : falloff[CH_W-2:0];
            ax  = (px >= rad) ? px - rad : rad - px;
            ay  = (py >= rad) ? py - rad : rad - py;
            dsq = ax * ax + ay * ay;
            if (dsq > rad * rad)
                return '0;
            dist_q = int_sqrt(dsq << (2 * FRAC));
            // The half offset keeps the divisor away from zero.
            rel = 64'd1 << (FRAC - 1);
            if (rad != 0)
                rel += (dist_q * dim) / rad;
            quot = (64'd255 << (2 * FRAC - 2)) / (rel * rel);
            return (quot > ALPHA_MAX) ? ALPHA_MAX : quot[CH_W-1:0];
        endfunction

        function void note_coord(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            t_pixel p;
            p.red   = red;
            p.green = green;
            p.blue  = blue;
            p.alpha = glow_alpha(px, py);
            awaited.push_back(p);
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: pixel with nothing awaited: r=%0d g=%0d b=%0d a=%0d",
                             got.red, got.green, got.blue, got.alpha);
                return;
            end
            want = awaited.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                             want.red, want.green, want.blue, want.alpha,
                             got.red, got.green, got.blue, got.alpha);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;   // pixel_x[8:0], pixel_y[17:9], zeros
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;        // red, green, blue, alpha

    glow_scoreboard sb = new();
    bit             calm = 1'b0;
    bit             stall_req = 1'b0;

    radial_glow_alpha_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register write: a setup cycle, an access cycle, then a quiet cycle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] rad, input logic [7:0] fall,
                               input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_FALLOFF, fall);
        write_reg(REG_RED, r);
        write_reg(REG_GREEN, g);
        write_reg(REG_BLUE, b);
    endtask

    // Offers one coordinate request, with an occasional idle gap before it.
    task automatic offer_coord(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        if (!calm && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(24 - 2 * COORD_W){1'b0}}, py, px};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_coord(px, py);
    endtask

    // Stops offering and waits until every predicted pixel has come back.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly coordinates inside the sprite square, the rest anywhere in the field.
    function automatic logic [COORD_W-1:0] pick_coord(int rad);
        if (rad == 0 || $urandom_range(99) < 20)
            return COORD_W'($urandom_range(2 ** COORD_W - 1));
        return COORD_W'($urandom_range(2 * rad - 1));
    endfunction

    task automatic run_phase(input logic [7:0] rad, input logic [7:0] fall,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input int count);
        load_config(rad, fall, r, g, b);
        for (int n = 0; n < count; n++)
            offer_coord(pick_coord(rad), pick_coord(rad));
        drain_pixels();
    endtask

    // Pixel sink: checks each accepted pixel and throttles tready.
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata);
            if (stall_req) begin
                held      = HOLD_OFF;
                stall_req = 1'b0;
            end
            if (held > 0) begin
                held--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 37);
            end
        end
    end

    // Stimulus and final verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: centre, circle edges, sprite corners and points beyond the sprite.
        offer_coord(16, 16);
        offer_coord(0, 16);
        offer_coord(16, 0);
        offer_coord(17, 16);
        offer_coord(16, 28);
        offer_coord(0, 0);
        offer_coord(31, 31);
        offer_coord(32, 16);
        offer_coord(511, 511);
        drain_pixels();

        // Zero radius: only the origin lies inside.
        load_config(8'd0, 8'd5, 8'd0, 8'd0, 8'd0);
        offer_coord(0, 0);
        offer_coord(1, 0);
        offer_coord(0, 1);
        offer_coord(511, 0);
        drain_pixels();

        // Zero falloff at the largest radius: full alpha everywhere inside.
        load_config(8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        offer_coord(255, 255);
        offer_coord(0, 255);
        offer_coord(509, 509);
        offer_coord(128, 300);
        drain_pixels();

        // Most negative falloff falls back to the default steepness.
        load_config(8'd200, 8'h80, 8'd1, 8'd128, 8'd254);
        offer_coord(200, 200);
        offer_coord(100, 200);
        offer_coord(0, 200);
        offer_coord(400, 200);
        drain_pixels();

        // Random phases over several settings, the extremes among them.
        run_phase(8'd255, 8'd127, 8'd0, 8'd0, 8'd0, 200);
        run_phase(8'd1, 8'h80, 8'd255, 8'd0, 8'd170, 150);
        // No idling, with a long sink hold-off so that the pipeline fills and backs up.
        calm      = 1'b1;
        stall_req = 1'b1;
        run_phase(8'd16, 8'd4, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 200);
        calm = 1'b0;
        repeat (5)
            run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 130);

        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a stalled pipeline.
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
